[rtl/core/tsla_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Thumb shift and logic ALU package
// Shared types, operation codes and constants for the three pipeline stages
// and the top level of the shift and logic execute unit.
// ---------------------------------------------------------------------------
package tsla_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned AMT_W  = 5;
   localparam logic [DATA_W-1:0] SIGN_BIT = 32'h8000_0000;

   typedef enum logic [3:0] {
      OP_LSL   = 4'd0,
      OP_LSR   = 4'd1,
      OP_ASR   = 4'd2,
      OP_ROR   = 4'd3,
      OP_BIC   = 4'd4,
      OP_MVN   = 4'd5,
      OP_RSB   = 4'd6,
      OP_REV   = 4'd7,
      OP_REV16 = 4'd8,
      OP_REVSH = 4'd9
   } op_type;

   // Input transaction.
   typedef struct packed {
      logic [3:0]        req_type;
      logic [DATA_W-1:0] operand_a;
      logic [DATA_W-1:0] operand_b;
      logic              carry_in;
   } req_payload_type;

   // Result transaction.
   typedef struct packed {
      logic [DATA_W-1:0] result_value;
      logic              neg_flag;
      logic              zero_flag;
      logic              carry_flag;
      logic              overflow_flag;
      logic              flags_written;
      logic              overflow_written;
   } rsp_payload_type;

   // Decode stage output.
   typedef struct packed {
      op_type            op;
      logic              is_shift;
      logic [DATA_W-1:0] operand_a;
      logic [AMT_W-1:0]  amt_low;
      logic              amt_zero;
      logic              amt_eq32;
      logic              amt_gt32;
      logic              carry_in;
      logic [DATA_W-1:0] simple_res;
      logic              simple_carry;
      logic              overflow;
      logic              flags_written;
      logic              overflow_written;
   } dec_type;

   // Execute stage output.
   typedef struct packed {
      logic [DATA_W-1:0] result;
      logic              carry;
      logic              overflow;
      logic              flags_written;
      logic              overflow_written;
   } exe_type;

endpackage

[rtl/core/tsla_decode.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Decode stage
// Classifies the shift amount and computes the results of the non-shift
// operations (BIC, MVN, RSB and the byte reversals).
// ---------------------------------------------------------------------------
module tsla_decode import tsla_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  req_payload_type in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output dec_type         out_data
);

   logic    valid_ff, valid_in;
   dec_type data_ff,  data_in;
   logic [7:0] amt;
   logic [DATA_W-1:0] a;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   assign amt = in_data.operand_b[7:0];
   assign a   = in_data.operand_a;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_comb begin
      data_in                  = '0;
      data_in.op               = op_type'(in_data.req_type);
      data_in.operand_a        = a;
      data_in.amt_low          = amt[AMT_W-1:0];
      data_in.amt_zero         = (amt == 8'd0);
      data_in.amt_eq32         = (amt == 8'd32);
      data_in.amt_gt32         = (amt > 8'd32);
      data_in.carry_in         = in_data.carry_in;
      data_in.simple_carry     = in_data.carry_in;
      unique case (in_data.req_type)
         OP_LSL, OP_LSR, OP_ASR, OP_ROR: begin
            data_in.is_shift      = 1'b1;
            data_in.flags_written = 1'b1;
         end
         OP_BIC: begin
            data_in.simple_res    = a & ~in_data.operand_b;
            data_in.flags_written = 1'b1;
         end
         OP_MVN: begin
            data_in.simple_res    = ~a;
            data_in.flags_written = 1'b1;
         end
         OP_RSB: begin
            data_in.simple_res       = '0 - a;
            data_in.simple_carry     = (a == '0);
            data_in.overflow         = (a == SIGN_BIT);
            data_in.flags_written    = 1'b1;
            data_in.overflow_written = 1'b1;
         end
         OP_REV: begin
            data_in.simple_res = {a[7:0], a[15:8], a[23:16], a[31:24]};
         end
         OP_REV16: begin
            data_in.simple_res = {a[23:16], a[31:24], a[7:0], a[15:8]};
         end
         OP_REVSH: begin
            data_in.simple_res = {{16{a[7]}}, a[7:0], a[15:8]};
         end
         default: begin
            data_in.simple_res = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

[rtl/core/tsla_exec.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Execute stage
// Barrel shifter for LSL, LSR, ASR and ROR with the Thumb rules for an
// amount of zero, of 32 and above; passes other results through.
// ---------------------------------------------------------------------------
module tsla_exec import tsla_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  dec_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output exe_type out_data
);

   logic    valid_ff, valid_in;
   exe_type data_ff,  data_in;
   logic [DATA_W:0]     lsl_ext;
   logic [DATA_W:0]     lsr_ext;
   logic [DATA_W:0]     asr_ext;
   logic [2*DATA_W-1:0] ror_ext;
   logic [DATA_W-1:0]   a;
   logic                a_msb;
   logic                big;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   assign a     = in_data.operand_a;
   assign a_msb = a[DATA_W-1];
   assign big   = in_data.amt_eq32 || in_data.amt_gt32;

   // The extra bit beside the operand catches the last bit shifted out.
   assign lsl_ext = {1'b0, a} << in_data.amt_low;
   assign lsr_ext = {a, 1'b0} >> in_data.amt_low;
   assign asr_ext = $unsigned($signed({a, 1'b0}) >>> in_data.amt_low);
   assign ror_ext = {a, a} >> in_data.amt_low;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_comb begin
      data_in.result           = in_data.simple_res;
      data_in.carry            = in_data.simple_carry;
      data_in.overflow         = in_data.overflow;
      data_in.flags_written    = in_data.flags_written;
      data_in.overflow_written = in_data.overflow_written;
      if (in_data.is_shift && !in_data.amt_zero) begin
         unique case (in_data.op)
            OP_LSL: begin
               if (in_data.amt_gt32) begin
                  data_in.result = '0;
                  data_in.carry  = 1'b0;
               end else if (in_data.amt_eq32) begin
                  data_in.result = '0;
                  data_in.carry  = a[0];
               end else begin
                  data_in.result = lsl_ext[DATA_W-1:0];
                  data_in.carry  = lsl_ext[DATA_W];
               end
            end
            OP_LSR: begin
               if (in_data.amt_gt32) begin
                  data_in.result = '0;
                  data_in.carry  = 1'b0;
               end else if (in_data.amt_eq32) begin
                  data_in.result = '0;
                  data_in.carry  = a_msb;
               end else begin
                  data_in.result = lsr_ext[DATA_W:1];
                  data_in.carry  = lsr_ext[0];
               end
            end
            OP_ASR: begin
               if (big) begin
                  data_in.result = {DATA_W{a_msb}};
                  data_in.carry  = a_msb;
               end else begin
                  data_in.result = asr_ext[DATA_W:1];
                  data_in.carry  = asr_ext[0];
               end
            end
            OP_ROR: begin
               // A multiple of 32 leaves the operand and takes bit 31 as carry.
               data_in.result = ror_ext[DATA_W-1:0];
               data_in.carry  = ror_ext[DATA_W-1];
            end
            default: begin
               data_in.result = in_data.simple_res;
            end
         endcase
      end else if (in_data.is_shift) begin
         data_in.result = a;
         data_in.carry  = in_data.carry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

[rtl/core/tsla_flags.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Flag stage
// Forms the N and Z flags from the result and holds the output register.
// ---------------------------------------------------------------------------
module tsla_flags import tsla_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  exe_type         in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output rsp_payload_type out_data
);

   logic            valid_ff, valid_in;
   rsp_payload_type data_ff,  data_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_comb begin
      data_in.result_value     = in_data.result;
      data_in.neg_flag         = in_data.flags_written && in_data.result[DATA_W-1];
      data_in.zero_flag        = in_data.flags_written && (in_data.result == '0);
      data_in.carry_flag       = in_data.carry;
      data_in.overflow_flag    = in_data.overflow;
      data_in.flags_written    = in_data.flags_written;
      data_in.overflow_written = in_data.overflow_written;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

[rtl/core/thumb_shift_logic_alu_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Thumb shift and logic ALU core
// Three-stage execute unit for LSL, LSR, ASR, ROR, BIC, MVN, RSB, REV,
// REV16 and REVSH with N, Z, C and V flag generation.
// ---------------------------------------------------------------------------
// The unit accepts one transaction per clock cycle while the result side is
// not stalled and returns exactly one result transaction for each, in order.
// Every transaction passes in order through the three register
// stages: decode (shift amount classification and the non-shift operations),
// execute (the 32-bit barrel shifter) and flags (zero detect and the output
// register). Each stage holds its own valid bit and takes a new transaction
// whenever it is empty or its contents move on in the same cycle, so a
// stall on the result side backs up through the stages without losing or
// repeating anything. The shift amount is the low byte of operand_b; an
// amount of zero leaves the operand and the carry unchanged, and amounts of
// 32 and above follow the Thumb register-shift rules. Operation codes
// 10 to 15 return zero with the carry kept and no flags written. The unit
// holds no architectural state, so reset only empties the pipeline.
// ---------------------------------------------------------------------------
module thumb_shift_logic_alu_core import tsla_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic    dec_valid, dec_ready;
   dec_type dec_data;
   logic    exe_valid, exe_ready;
   exe_type exe_data;

   // Stage one: decode and the operations that need no shifter.
   tsla_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_payload),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_data  (dec_data)
   );

   // Stage two: the barrel shifter and result selection.
   tsla_exec u_exec (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (exe_valid),
      .out_ready (exe_ready),
      .out_data  (exe_data)
   );

   // Stage three: N and Z flags and the output register.
   tsla_flags u_flags (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (exe_valid),
      .in_ready  (exe_ready),
      .in_data   (exe_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_payload)
   );

   // An accepted transaction must land in the decode stage.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> dec_valid)
      else $error("accepted transaction did not reach the decode stage");

   // A transaction leaving the execute stage must reach the output register.
   assert property (@(posedge clock) disable iff (reset)
      exe_valid && exe_ready |=> rsp_valid)
      else $error("transaction lost between execute and flag stages");

   // N and Z may only be set by operations that write the flags.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.flags_written |->
         !rsp_payload.neg_flag && !rsp_payload.zero_flag)
      else $error("N or Z set without flags being written");

   // V is only ever written together with N, Z and C.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.overflow_written |-> rsp_payload.flags_written)
      else $error("V written without N, Z and C");

endmodule

[tb/sv/tb_thumb_shift_logic_alu_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Thumb shift and logic ALU core testbench
// Self-checking bench for thumb_shift_logic_alu_core. A short table of
// hand-picked instructions covers each operation, the shift amount edge
// cases and one unused code. Random instructions follow, run under changing
// patterns of sender gaps and result-side stalls. Every result is compared
// field by field with a behavioural model of the unit or a typed-in result.
// ---------------------------------------------------------------------------
module tb_thumb_shift_logic_alu_core;
   import tsla_pkg::*;

   // Operation codes 10 to 15 have no instruction behind them.
   localparam logic [3:0] OP_SPARE_FIRST = 4'd10;
   localparam logic [3:0] OP_SPARE_LAST  = 4'd15;

   localparam int RESET_CYCLES  = 5;
   localparam int DIR_ROWS      = 25;
   localparam int RANDOM_ITEMS  = 1525;
   localparam int PHASE_COUNT   = 6;
   localparam int DRAIN_CYCLES  = 12;     // extra wait for stray results after draining
   localparam int STALL_LIMIT   = 2000;   // cycles in a row with no transaction
   localparam int MAX_REPORTS   = 40;

   // Idling patterns for the two channels.
   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SEND,
      IDLE_RECV,
      IDLE_BOTH
   } idle_mode_type;

   // One row of the directed table. When has_fixed is set, the expected
   // result is the one typed in the row; otherwise the model supplies it.
   typedef struct {
      req_payload_type req;
      bit              has_fixed;
      rsp_payload_type rsp;
   } dir_row_type;

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready   = 1'b0;
   rsp_payload_type rsp_payload;

   // The expectation that travels with the instruction currently on the
   // request port, used only for table rows with a typed-in result.
   bit              req_has_fixed = 1'b0;
   rsp_payload_type req_fixed_rsp = '0;

   rsp_payload_type pending_results[$];
   int              error_count     = 0;
   int              results_checked = 0;
   int              items_sent      = 0;
   int              idle_cycles     = 0;
   int unsigned     send_gap_pct    = 0;
   int unsigned     recv_stall_pct  = 0;

   // Row fields: {op, operand_a, operand_b, carry_in}, typed flag, and the
   // result as {value, N, Z, C, V, flags written, overflow written}.
   dir_row_type directed_rows [DIR_ROWS] = '{
      // Shift by zero: operand and carry pass through untouched.
      '{'{OP_LSL, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1}, 1'b1,
        '{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0}},
      // LSL by exactly 32 moves bit 0 into the carry.
      '{'{OP_LSL, 32'h0000_0001, 32'h0000_0020, 1'b0}, 1'b1,
        '{32'h0000_0000, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0}},
      // LSL beyond 32 clears both result and carry.
      '{'{OP_LSL, 32'hFFFF_FFFF, 32'h0000_0021, 1'b1}, 1'b1,
        '{32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0}},
      '{'{OP_LSL, 32'h8000_0001, 32'h0000_0001, 1'b0}, 1'b0, '0},
      // Only the low byte counts as the amount.
      '{'{OP_LSL, 32'hFFFF_FFFF, 32'hFFFF_FF1F, 1'b0}, 1'b0, '0},
      '{'{OP_LSR, 32'h8000_0000, 32'h0000_0020, 1'b0}, 1'b1,
        '{32'h0000_0000, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0}},
      // Amount byte is zero although higher bits of operand_b are set.
      '{'{OP_LSR, 32'hFFFF_FFFF, 32'h0000_0100, 1'b0}, 1'b1,
        '{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}},
      '{'{OP_LSR, 32'hFFFF_FFFF, 32'h0000_00FF, 1'b1}, 1'b1,
        '{32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0}},
      '{'{OP_LSR, 32'hFFFF_FFFF, 32'h0000_001F, 1'b0}, 1'b0, '0},
      // ASR of 32 or more fills with the sign bit.
      '{'{OP_ASR, 32'h8000_0000, 32'h0000_0020, 1'b0}, 1'b1,
        '{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0}},
      '{'{OP_ASR, 32'h7FFF_FFFF, 32'h0000_00C8, 1'b1}, 1'b1,
        '{32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0}},
      '{'{OP_ASR, 32'h8000_0000, 32'h0000_001F, 1'b0}, 1'b0, '0},
      // ROR by a nonzero multiple of 32 keeps the value; carry takes bit 31.
      '{'{OP_ROR, 32'h8000_0001, 32'h0000_0040, 1'b0}, 1'b1,
        '{32'h8000_0001, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0}},
      '{'{OP_ROR, 32'h0000_0001, 32'h0000_0021, 1'b0}, 1'b0, '0},
      '{'{OP_ROR, 32'h1234_5678, 32'hFFFF_FF00, 1'b1}, 1'b1,
        '{32'h1234_5678, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0}},
      // BIC keeps the incoming carry.
      '{'{OP_BIC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}, 1'b1,
        '{32'h0000_0000, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0}},
      '{'{OP_BIC, 32'hA5A5_A5A5, 32'h0F0F_0F0F, 1'b0}, 1'b0, '0},
      '{'{OP_MVN, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0}, 1'b1,
        '{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}},
      // Negating zero is the one case without a borrow.
      '{'{OP_RSB, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b1,
        '{32'h0000_0000, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1}},
      // Negating the most negative value overflows.
      '{'{OP_RSB, 32'h8000_0000, 32'h0000_0000, 1'b1}, 1'b1,
        '{32'h8000_0000, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1}},
      '{'{OP_RSB, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1}, 1'b0, '0},
      '{'{OP_REV, 32'h1234_5678, 32'h0000_0000, 1'b1}, 1'b1,
        '{32'h7856_3412, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
      '{'{OP_REV16, 32'h1234_5678, 32'h0000_0000, 1'b0}, 1'b1,
        '{32'h3412_7856, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      // REVSH sign-extends from the byte that lands in bit 15.
      '{'{OP_REVSH, 32'h0000_0080, 32'h0000_0000, 1'b0}, 1'b1,
        '{32'hFFFF_8000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      // Unused code: zero result, carry kept, nothing written.
      '{'{OP_SPARE_LAST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}, 1'b1,
        '{32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}}
   };

   idle_mode_type phase_modes [PHASE_COUNT] = '{
      IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE, IDLE_SEND
   };

   thumb_shift_logic_alu_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #6 clock = ~clock;

   // Behavioural model of the execute unit: works out the result and the
   // flags for one instruction. The unit is stateless, so this is all the
   // prediction there is.
   function automatic rsp_payload_type predict_alu_result(input req_payload_type r);
      rsp_payload_type outcome;
      logic [31:0]     a;
      logic [31:0]     res;
      logic [7:0]      amt;
      logic [4:0]      rot;
      logic            c;
      logic            v;
      logic            fw;
      logic            vw;
      a   = r.operand_a;
      amt = r.operand_b[7:0];
      res = '0;
      c   = r.carry_in;
      v   = 1'b0;
      fw  = 1'b0;
      vw  = 1'b0;
      case (r.req_type)
         OP_LSL: begin
            fw = 1'b1;
            if (amt == 0) begin
               res = a;
            end else if (amt < 32) begin
               res = a << amt;
               c   = a[32 - amt];
            end else if (amt == 32) begin
               c = a[0];
            end else begin
               c = 1'b0;
            end
         end
         OP_LSR: begin
            fw = 1'b1;
            if (amt == 0) begin
               res = a;
            end else if (amt < 32) begin
               res = a >> amt;
               c   = a[amt - 1];
            end else if (amt == 32) begin
               c = a[31];
            end else begin
               c = 1'b0;
            end
         end
         OP_ASR: begin
            fw = 1'b1;
            if (amt == 0) begin
               res = a;
            end else if (amt < 32) begin
               res = $signed(a) >>> amt;
               c   = a[amt - 1];
            end else begin
               res = {32{a[31]}};
               c   = a[31];
            end
         end
         OP_ROR: begin
            fw = 1'b1;
            if (amt == 0) begin
               res = a;
            end else begin
               rot = amt[4:0];
               res = (rot == 0) ? a : ((a >> rot) | (a << (32 - rot)));
               c   = res[31];
            end
         end
         OP_BIC: begin
            fw  = 1'b1;
            res = a & ~r.operand_b;
         end
         OP_MVN: begin
            fw  = 1'b1;
            res = ~a;
         end
         OP_RSB: begin
            fw  = 1'b1;
            vw  = 1'b1;
            res = -a;
            c   = (a == 0);
            v   = (a == SIGN_BIT);
         end
         OP_REV:   res = {a[7:0], a[15:8], a[23:16], a[31:24]};
         OP_REV16: res = {a[23:16], a[31:24], a[7:0], a[15:8]};
         OP_REVSH: res = {{16{a[7]}}, a[7:0], a[15:8]};
         default:  res = '0;
      endcase
      outcome.result_value     = res;
      outcome.neg_flag         = fw & res[31];
      outcome.zero_flag        = fw & (res == 0);
      outcome.carry_flag       = c;
      outcome.overflow_flag    = v;
      outcome.flags_written    = fw;
      outcome.overflow_written = vw;
      return outcome;
   endfunction

   // Random instruction. Shift amounts are steered towards the edge classes
   // (zero, exactly 32, multiples of 32, above 32) and operands towards the
   // values that make the flags interesting. The unused codes turn up now
   // and then.
   function automatic req_payload_type random_instruction();
      req_payload_type r;
      logic [7:0]      amt;
      if ($urandom_range(99) < 5) begin
         r.req_type = 4'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
      end else begin
         r.req_type = 4'($urandom_range(OP_REVSH, OP_LSL));
      end
      case ($urandom_range(7))
         0:       r.operand_a = 32'h0000_0000;
         1:       r.operand_a = SIGN_BIT;
         2:       r.operand_a = 32'hFFFF_FFFF;
         3:       r.operand_a = $urandom_range(1) ? 32'h0000_0001 : 32'h7FFF_FFFF;
         default: r.operand_a = $urandom;
      endcase
      case ($urandom_range(9))
         0:       amt = 8'd0;
         1:       amt = 8'd32;
         2:       amt = 8'($urandom_range(255, 33));
         3:       amt = 8'(32 * $urandom_range(7, 2));
         default: amt = 8'($urandom_range(31, 1));
      endcase
      r.operand_b = $urandom;
      if (r.req_type != OP_BIC) begin
         r.operand_b[7:0] = amt;
      end
      r.carry_in = 1'($urandom_range(1));
      return r;
   endfunction

   // One line per mismatch, capped so a badly broken unit cannot flood the
   // log; every mismatch is still counted.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("MISMATCH result %0d: %s got %h expected %h",
                  results_checked, what, got, want);
      end
   endtask

   task automatic compare_result(input rsp_payload_type got, input rsp_payload_type want);
      if (got.result_value !== want.result_value)
         report_mismatch("result_value", got.result_value, want.result_value);
      if (got.neg_flag !== want.neg_flag)
         report_mismatch("neg_flag", 32'(got.neg_flag), 32'(want.neg_flag));
      if (got.zero_flag !== want.zero_flag)
         report_mismatch("zero_flag", 32'(got.zero_flag), 32'(want.zero_flag));
      if (got.carry_flag !== want.carry_flag)
         report_mismatch("carry_flag", 32'(got.carry_flag), 32'(want.carry_flag));
      if (got.overflow_flag !== want.overflow_flag)
         report_mismatch("overflow_flag", 32'(got.overflow_flag),
                         32'(want.overflow_flag));
      if (got.flags_written !== want.flags_written)
         report_mismatch("flags_written", 32'(got.flags_written),
                         32'(want.flags_written));
      if (got.overflow_written !== want.overflow_written)
         report_mismatch("overflow_written", 32'(got.overflow_written),
                         32'(want.overflow_written));
   endtask

   task automatic set_idle_mode(input idle_mode_type mode);
      case (mode)
         IDLE_SEND: begin
            send_gap_pct   = 59;
            recv_stall_pct = 0;
         end
         IDLE_RECV: begin
            send_gap_pct   = 0;
            recv_stall_pct = 59;
         end
         IDLE_BOTH: begin
            send_gap_pct   = 7;
            recv_stall_pct = 7;
         end
         default: begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
         end
      endcase
   endtask

   // Presents one instruction and holds it until the unit takes it. Gaps are
   // inserted beforehand at the current sender rate. Valid is only ever
   // given one value per clock edge: a new instruction that follows straight
   // on keeps valid high, and a gap lowers it.
   task automatic issue_instruction(input req_payload_type r, input bit has_fixed,
                                    input rsp_payload_type fixed_rsp);
      while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_payload   <= r;
      req_has_fixed <= has_fixed;
      req_fixed_rsp <= fixed_rsp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // Result-side back-pressure at the current stall rate.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Scoreboard. An accepted instruction queues its expected result before
   // any result of the same edge is checked, so the order of the two
   // handshakes within one edge does not matter.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            pending_results.push_back(req_has_fixed ? req_fixed_rsp
                                                    : predict_alu_result(req_payload));
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected result_value", rsp_payload.result_value, '0);
            end else begin
               compare_result(rsp_payload, pending_results.pop_front());
            end
            results_checked++;
         end
      end
   end

   // Watchdog: a run in which nothing moves for too long has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
         $display("tb_thumb_shift_logic_alu_core: done, errors");
         $finish;
      end
   end

   initial begin
      int per_phase;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table, run back to back with no idling.
      set_idle_mode(IDLE_NONE);
      for (int i = 0; i < DIR_ROWS; i++) begin
         issue_instruction(directed_rows[i].req, directed_rows[i].has_fixed,
                           directed_rows[i].rsp);
      end

      // Random instructions, the idling pattern changing from phase to phase.
      per_phase = RANDOM_ITEMS / PHASE_COUNT;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         set_idle_mode(phase_modes[p]);
         for (int i = 0; i < per_phase; i++) begin
            issue_instruction(random_instruction(), 1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      // Drain the pipeline, then give any stray result time to show up.
      set_idle_mode(IDLE_NONE);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         report_mismatch("missing results", pending_results.size(), '0);
      end

      $display("Sent %0d instructions (%0d from the directed table) and checked %0d results,",
               items_sent, DIR_ROWS, results_checked);
      $display("under no idling, sender gaps, result stalls and both; %0d mismatches.",
               error_count);
      if (error_count == 0) begin
         $display("tb_thumb_shift_logic_alu_core: done, clean");
      end else begin
         $display("tb_thumb_shift_logic_alu_core: done, errors");
      end
      $finish;
   end

endmodule
